// ===== rtl/core/keypad_scan_debounce_encoder_assert.svh =====
// Assertion macros shared by the key queue and nibble sender modules.
`ifndef KEYPAD_SCAN_DEBOUNCE_ENCODER_ASSERT_SVH
`define KEYPAD_SCAN_DEBOUNCE_ENCODER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define KSDE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad assertion failed");

// Next-cycle implication, held off during reset.
`define KSDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad assertion failed");

`endif

// ===== rtl/core/ksde_pkg.sv =====
// Package with types, constants and helper functions of the keypad scanner.
package ksde_pkg;

  localparam int NUM_ROWS = 4;
  localparam int NUM_COLS = 3;
  localparam int IN_W     = 12;
  localparam int KEY_W    = 4;
  localparam int THR_W    = 8;
  localparam int NUM_KEYS = NUM_ROWS * NUM_COLS;
  localparam int NUM_ENC0 = (NUM_KEYS > 15) ? 15 : NUM_KEYS;
  localparam int NUM_ENC  = (NUM_ENC0 > IN_W) ? IN_W : NUM_ENC0;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [THR_W-1:0] thr_t;
  typedef logic [1:0]       zcnt_t;

  localparam key_t KEY_NONE = key_t'(0);
  localparam key_t KEY_TEN  = key_t'(10);
  localparam key_t KEY_ELEV = key_t'(11);
  localparam key_t KEY_TWLV = key_t'(12);

  localparam thr_t THR_RESET = thr_t'(255);
  localparam thr_t THR_MAX   = thr_t'(255);

  // Register index, taken from paddr[2].
  localparam logic REG_DEBOUNCE_THRESHOLD = 1'b0;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Lowest pressed key as 1..NUM_ENC, or none.
  function automatic key_t encode_lowest(input logic [IN_W-1:0] snap);
    key_t k;
    k = KEY_NONE;
    for (int i = NUM_ENC - 1; i >= 0; i--) begin
      if (snap[i]) begin
        k = key_t'(i + 1);
      end
    end
    return k;
  endfunction

  // Number of zero nibbles that stand for a key; zero means send the key itself.
  function automatic zcnt_t zero_count(input key_t k);
    zcnt_t z;
    unique case (k)
      KEY_ELEV: z = zcnt_t'(1);
      KEY_TEN:  z = zcnt_t'(2);
      KEY_TWLV: z = zcnt_t'(3);
      default:  z = zcnt_t'(0);
    endcase
    return z;
  endfunction

endpackage

// ===== rtl/core/ksde_front.sv =====
// Front end: priority encode, debounce and pick keys to report.
module ksde_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [ksde_pkg::IN_W-1:0] pressed_keys,
  input  ksde_pkg::thr_t        threshold,
  input  logic                  full,
  output logic                  ev_valid,
  output ksde_pkg::key_t        ev_key
);
  import ksde_pkg::*;

  logic debouncing, debouncing_next;
  key_t candidate_key, candidate_key_next;
  thr_t equal_count, equal_count_next;
  key_t last_reported_key, last_reported_key_next;

  logic accept;
  key_t code;
  thr_t cnt_inc;

  assign accept  = push && !full;
  assign code    = encode_lowest(pressed_keys);
  assign cnt_inc = (equal_count == THR_MAX) ? equal_count : equal_count + thr_t'(1);
  assign ev_key  = candidate_key;

  always_comb begin
    debouncing_next        = debouncing;
    candidate_key_next     = candidate_key;
    equal_count_next       = equal_count;
    last_reported_key_next = last_reported_key;
    ev_valid               = 1'b0;
    if (accept) begin
      if (!debouncing) begin
        if (code != KEY_NONE) begin
          debouncing_next    = 1'b1;
          candidate_key_next = code;
          equal_count_next   = '0;
        end
      end else if (code == candidate_key) begin
        if (cnt_inc >= threshold) begin
          // settled: drop back to idle, report on change
          debouncing_next  = 1'b0;
          equal_count_next = '0;
          if (candidate_key != last_reported_key) begin
            last_reported_key_next = candidate_key;
            ev_valid               = (candidate_key != KEY_NONE);
          end
        end else begin
          equal_count_next = cnt_inc;
        end
      end else begin
        candidate_key_next = code;
        equal_count_next   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debouncing        <= 1'b0;
      candidate_key     <= KEY_NONE;
      equal_count       <= '0;
      last_reported_key <= KEY_NONE;
    end else begin
      debouncing        <= debouncing_next;
      candidate_key     <= candidate_key_next;
      equal_count       <= equal_count_next;
      last_reported_key <= last_reported_key_next;
    end
  end

endmodule

// ===== rtl/core/ksde_fifo.sv =====
// Short key queue between the front end and the nibble sender.
`include "keypad_scan_debounce_encoder_assert.svh"
module ksde_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr,
  input  ksde_pkg::key_t       wr_key,
  input  logic                 rd,
  output ksde_pkg::key_t       rd_key,
  output ksde_pkg::fifo_stat_t stat
);
  import ksde_pkg::*;

  key_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_CW-1:0] count;

  assign stat.full  = (count == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign rd_key     = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + FIFO_AW'(1);
      end
      if (rd) begin
        rptr <= rptr + FIFO_AW'(1);
      end
      case ({wr, rd})
        2'b10:   count <= count + FIFO_CW'(1);
        2'b01:   count <= count - FIFO_CW'(1);
        default: count <= count;
      endcase
    end
  end

  `KSDE_ASSERT_SAME(a_no_write_full, clk, rst, wr, !stat.full)
  `KSDE_ASSERT_SAME(a_no_read_empty, clk, rst, rd, !stat.empty)
  `KSDE_ASSERT_NEXT(a_count_up, clk, rst, wr && !rd, count == $past(count) + FIFO_CW'(1))

endmodule

// ===== rtl/core/ksde_back.sv =====
// Back end: expand each reported key into one to three nibbles.
`include "keypad_scan_debounce_encoder_assert.svh"
module ksde_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ksde_pkg::fifo_stat_t fstat,
  input  ksde_pkg::key_t       fkey,
  output logic                 fpop,
  input  logic                 pop,
  output logic                 empty,
  output logic [3:0]           nibble,
  output logic                 last
);
  import ksde_pkg::*;

  logic  cur_valid;
  logic  cur_zero;
  key_t  cur_key;
  zcnt_t cur_left;
  zcnt_t zc;
  logic  take;
  logic  done;

  assign take   = pop && cur_valid;
  assign done   = !cur_valid || (take && (cur_left == zcnt_t'(1)));
  assign fpop   = done && !fstat.empty;
  assign zc     = zero_count(fkey);
  assign empty  = !cur_valid;
  assign last   = (cur_left == zcnt_t'(1));
  assign nibble = cur_zero ? 4'(0) : 4'(cur_key);

  always_ff @(posedge clk) begin
    if (fpop) begin
      cur_key  <= fkey;
      cur_zero <= (zc != zcnt_t'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_left  <= '0;
    end else if (fpop) begin
      cur_valid <= 1'b1;
      cur_left  <= (zc == zcnt_t'(0)) ? zcnt_t'(1) : zc;
    end else if (done) begin
      cur_valid <= 1'b0;
      cur_left  <= '0;
    end else if (take) begin
      cur_left  <= cur_left - zcnt_t'(1);
    end
  end

  `KSDE_ASSERT_SAME(a_left_nonzero, clk, rst, cur_valid, cur_left != zcnt_t'(0))
  `KSDE_ASSERT_SAME(a_multi_is_zero, clk, rst, cur_valid && !last, cur_zero)
  `KSDE_ASSERT_NEXT(a_hold_on_stall, clk, rst, cur_valid && !pop,
                    cur_valid && $stable(nibble) && $stable(last))

endmodule

// ===== rtl/core/keypad_scan_debounce_encoder.sv =====
// Top level of the keypad scanner: debounce front end, key queue, nibble sender.
// Path: with an idle sender, a snapshot transfer that settles a key writes it to the
//   queue; the sender then loads it and puts its first nibble on the result ports.
// Throughput: one snapshot and one result transfer per cycle; a key sends up to three
//   nibbles, and full rises once the 4-entry queue fills while results are held off.
// Reset (rst, synchronous): idle, no key reported, queue and sender empty, threshold 255.
module keypad_scan_debounce_encoder (
  input  logic                          clk,
  input  logic                          rst,
  // snapshot input
  input  logic                          push,
  output logic                          full,
  input  logic [ksde_pkg::IN_W-1:0]     pressed_keys,
  // result output
  output logic                          empty,
  input  logic                          pop,
  output logic [3:0]                    nibble,
  output logic                          last,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ksde_pkg::APB_AW-1:0]   paddr,
  input  logic [ksde_pkg::APB_DW-1:0]   pwdata,
  output logic [ksde_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import ksde_pkg::*;

  thr_t       debounce_threshold;
  logic       cfg_wr;
  logic       ev_valid;
  key_t       ev_key;
  key_t       q_key;
  logic       q_pop;
  fifo_stat_t q_stat;

  // Register file: one 8-bit register at byte address 0; paddr[2] picks the register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DEBOUNCE_THRESHOLD);
  assign prdata = (paddr[2] == REG_DEBOUNCE_THRESHOLD) ?
                  APB_DW'(debounce_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_threshold <= THR_RESET;
    end else if (cfg_wr) begin
      debounce_threshold <= pwdata[THR_W-1:0];
    end
  end

  // Snapshots stall only on a full queue; the front end never waits on the sender.
  assign full = q_stat.full;

  ksde_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .pressed_keys (pressed_keys),
    .threshold    (debounce_threshold),
    .full         (q_stat.full),
    .ev_valid     (ev_valid),
    .ev_key       (ev_key)
  );

  // Hold settled keys until the sender takes them.
  ksde_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (ev_valid),
    .wr_key (ev_key),
    .rd     (q_pop),
    .rd_key (q_key),
    .stat   (q_stat)
  );

  // Advance through the nibbles of one key per result transfer.
  ksde_back u_back (
    .clk    (clk),
    .rst    (rst),
    .fstat  (q_stat),
    .fkey   (q_key),
    .fpop   (q_pop),
    .pop    (pop),
    .empty  (empty),
    .nibble (nibble),
    .last   (last)
  );

endmodule
